// ===== src/necirtx_pkg.sv =====
// Shared types, constants and register map of the NEC infrared frame transmitter.
package necirtx_pkg;

    // Default payload widths of an NEC frame.
    localparam int ADDRESS_BITS_DEF = 16;
    localparam int COMMAND_BITS_DEF = 16;

    // Widths of the item fields on the stream ports.
    localparam int FIELD_W  = 16;
    localparam int S_DATA_W = 2 * FIELD_W;
    localparam int M_DATA_W = 8;

    // Widths of the timing state.
    localparam int TICK_W = 8;
    localparam int IDX_W  = 6;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE    = 3'd4;

    // Reset values of the tick-count registers.
    localparam logic [TICK_W-1:0] LEADER_MARK_RST  = 8'd129;
    localparam logic [TICK_W-1:0] LEADER_SPACE_RST = 8'd61;
    localparam logic [TICK_W-1:0] BIT_MARK_RST     = 8'd6;
    localparam logic [TICK_W-1:0] ZERO_SPACE_RST   = 8'd6;
    localparam logic [TICK_W-1:0] ONE_SPACE_RST    = 8'd24;

    // Input item kinds carried in tuser.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Segment durations as seen by the sequencer.
    typedef struct packed {
        logic [TICK_W-1:0] leader_mark_ticks;
        logic [TICK_W-1:0] leader_space_ticks;
        logic [TICK_W-1:0] bit_mark_ticks;
        logic [TICK_W-1:0] zero_space_ticks;
        logic [TICK_W-1:0] one_space_ticks;
    } t_cfg;

    // Frame segments, one-hot.
    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_LEAD_MARK  = 5'b00010,
        PH_LEAD_SPACE = 5'b00100,
        PH_BIT_MARK   = 5'b01000,
        PH_BIT_SPACE  = 5'b10000
    } t_phase;

endpackage

// ===== src/necirtx_cfg.sv =====
// APB register file holding the segment durations of the IR transmitter.
module necirtx_cfg
    import necirtx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [TICK_W-1:0]    wr_val;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_val  = pwdata[TICK_W-1:0];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_LEADER_MARK:  n_cfg.leader_mark_ticks  = wr_val;
                REG_LEADER_SPACE: n_cfg.leader_space_ticks = wr_val;
                REG_BIT_MARK:     n_cfg.bit_mark_ticks     = wr_val;
                REG_ZERO_SPACE:   n_cfg.zero_space_ticks   = wr_val;
                REG_ONE_SPACE:    n_cfg.one_space_ticks    = wr_val;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_mark_ticks  <= LEADER_MARK_RST;
            r_cfg.leader_space_ticks <= LEADER_SPACE_RST;
            r_cfg.bit_mark_ticks     <= BIT_MARK_RST;
            r_cfg.zero_space_ticks   <= ZERO_SPACE_RST;
            r_cfg.one_space_ticks    <= ONE_SPACE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Reads of unmapped addresses return zero.
    always_comb begin
        case (reg_idx)
            REG_LEADER_MARK:  prdata = APB_DATA_W'(r_cfg.leader_mark_ticks);
            REG_LEADER_SPACE: prdata = APB_DATA_W'(r_cfg.leader_space_ticks);
            REG_BIT_MARK:     prdata = APB_DATA_W'(r_cfg.bit_mark_ticks);
            REG_ZERO_SPACE:   prdata = APB_DATA_W'(r_cfg.zero_space_ticks);
            REG_ONE_SPACE:    prdata = APB_DATA_W'(r_cfg.one_space_ticks);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/nec_ir_frame_transmitter.sv =====
// Top level of the NEC infrared frame transmitter: frame sequencer and stream ports.
//
//  Channel   Direction  Payload                                    Accepted when
//  s_*       in         tuser: cmd; tdata: address, command        s_tvalid && s_tready
//  m_*       out        tdata: envelope, busy, done, rejected      m_tvalid && m_tready
//  APB       in         five 8-bit tick-count registers            psel&penable&pwrite
//
// The sequencer state and the result register are updated at the edge that
// accepts the item, so a new item can enter every cycle as long as the result
// register is empty or is being drained.
// The reset is synchronous and active low; it returns the sequencer to idle and
// loads the default NEC timings into the configuration registers.
// A stall on the output side holds the result register and lowers s_tready.
//
// Each item is either a tick or a start request. A start taken while idle loads
// the address and command into the payload shift register and opens the leader
// mark; a start while a frame is running is rejected and changes nothing. Each
// tick advances the segment counter, and when it reaches the current segment's
// duration the sequencer moves on: leader mark, leader space, then for every
// payload bit (address first, LSB first) a bit mark and a short or long space,
// and finally a stop bit that is sent as a zero. A tick while idle does nothing.
module nec_ir_frame_transmitter
    import necirtx_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] frame_address, [31:16] frame_command
    input  logic                  s_tuser,   // [0] cmd: tick or start request
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [0] ir_envelope, [1] busy_res,
                                             // [2] frame_done, [3] start_rejected,
                                             // [7:4] zero
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DATA_BITS = ADDRESS_BITS + COMMAND_BITS;

    t_cfg cfg;

    necirtx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer state.
    t_phase                r_phase;
    t_phase                n_phase;
    logic [TICK_W-1:0]     r_tick;
    logic [TICK_W-1:0]     n_tick;
    logic [IDX_W-1:0]      r_bit_idx;
    logic [IDX_W-1:0]      n_bit_idx;
    logic [DATA_BITS-1:0]  r_payload;
    logic [DATA_BITS-1:0]  n_payload;

    // Result register.
    logic                  r_m_valid;
    logic [M_DATA_W-1:0]   r_m_data;
    logic [M_DATA_W-1:0]   n_m_data;

    logic                  accept;
    logic                  busy;
    logic                  in_stop_bit;
    logic                  cur_bit;
    logic [TICK_W-1:0]     seg_len;
    logic [TICK_W-1:0]     tick_inc;
    logic                  done;
    logic                  rejected;
    logic                  envelope;

    // The result register is free when empty or being read in this cycle.
    assign s_tready = !r_m_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign busy     = (r_phase != PH_IDLE);

    // Past the last payload bit the sequencer is sending the stop bit, a zero.
    assign in_stop_bit = ({1'b0, r_bit_idx} >= (IDX_W + 1)'(DATA_BITS));
    assign cur_bit     = in_stop_bit ? 1'b0 : r_payload[0];
    assign tick_inc    = r_tick + 1'b1;

    always_comb begin
        case (r_phase)
            PH_LEAD_MARK:  seg_len = cfg.leader_mark_ticks;
            PH_LEAD_SPACE: seg_len = cfg.leader_space_ticks;
            PH_BIT_MARK:   seg_len = cfg.bit_mark_ticks;
            PH_BIT_SPACE:  seg_len = cur_bit ? cfg.one_space_ticks : cfg.zero_space_ticks;
            default:       seg_len = '0;
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit_idx = r_bit_idx;
        n_payload = r_payload;
        done      = 1'b0;
        rejected  = 1'b0;

        if (s_tuser == CMD_START) begin
            if (busy) begin
                rejected = 1'b1;
            end else begin
                n_payload = {COMMAND_BITS'(s_tdata[S_DATA_W-1:FIELD_W]),
                             ADDRESS_BITS'(s_tdata[FIELD_W-1:0])};
                n_bit_idx = '0;
                n_tick    = '0;
                n_phase   = PH_LEAD_MARK;
            end
        end else if (busy) begin
            // A zero duration behaves as one tick since the count is already 1.
            if (tick_inc >= seg_len) begin
                n_tick = '0;
                case (r_phase)
                    PH_LEAD_MARK: begin
                        n_phase = PH_LEAD_SPACE;
                    end
                    PH_LEAD_SPACE: begin
                        n_phase   = PH_BIT_MARK;
                        n_bit_idx = '0;
                    end
                    PH_BIT_MARK: begin
                        n_phase = PH_BIT_SPACE;
                    end
                    PH_BIT_SPACE: begin
                        if (in_stop_bit) begin
                            n_phase   = PH_IDLE;
                            n_bit_idx = '0;
                            n_payload = '0;
                            done      = 1'b1;
                        end else begin
                            n_payload = r_payload >> 1;
                            n_bit_idx = r_bit_idx + 1'b1;
                            n_phase   = PH_BIT_MARK;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else begin
                n_tick = tick_inc;
            end
        end
    end

    assign envelope = (n_phase == PH_LEAD_MARK) || (n_phase == PH_BIT_MARK);
    assign n_m_data = {4'b0000, rejected, done, (n_phase != PH_IDLE), envelope};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bit_idx <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_tick    <= n_tick;
                r_bit_idx <= n_bit_idx;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload and result data need no reset; they are only read once loaded.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= n_payload;
            r_m_data  <= n_m_data;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule
